### design/rcg_pkg.sv
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared types and constants for the resource claim and grant table.
// ----------------------------------------------------------------------------
package rcg_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = 8;
  localparam int TAG_W       = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
  localparam int SCN_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NUM_RES     = 3;

  localparam logic [CNT_W-1:0] POOL_RST_A = CNT_W'(10);
  localparam logic [CNT_W-1:0] POOL_RST_B = CNT_W'(5);
  localparam logic [CNT_W-1:0] POOL_RST_C = CNT_W'(7);

  typedef logic [NUM_RES-1:0][CNT_W-1:0] cnt3_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    cnt3_t            claim;
    cnt3_t            held;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_GRANT    = 2'd1,
    ACT_FINISH   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_OVER     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_TOTAL_A = 2'd0,
    REG_TOTAL_B = 2'd1,
    REG_TOTAL_C = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2
  } fsm_t;

endpackage

### design/rcg_in_if.sv
// ----------------------------------------------------------------------------
// rcg_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface rcg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] job_tag;
  logic [7:0]  amount_a;
  logic [7:0]  amount_b;
  logic [7:0]  amount_c;

  modport source (output valid, action, job_tag, amount_a, amount_b, amount_c,
                  input ready);
  modport sink (input valid, action, job_tag, amount_a, amount_b, amount_c,
                output ready);
endinterface

### design/rcg_out_if.sv
// ----------------------------------------------------------------------------
// rcg_out_if
// Result channel: valid/ready handshake with status and remaining pools.
// ----------------------------------------------------------------------------
interface rcg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] left_a;
  logic [7:0] left_b;
  logic [7:0] left_c;

  modport source (output valid, status, left_a, left_b, left_c, input ready);
  modport sink (input valid, status, left_a, left_b, left_c, output ready);
endinterface

### design/resource_claim_grant_table_unit.sv
// ----------------------------------------------------------------------------
// resource_claim_grant_table_unit
// Job table with claims and holdings of three resource types and three pools.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer when          | payload
//  in_ch     | in        | in_ch.valid & ready    | action, job_tag, amount_a/b/c
//  out_ch    | out       | out_ch.valid & ready   | status, left_a/b/c
//  cfg_*     | in        | cfg_we                 | cfg_idx, cfg_wdata
//
//  One command at a time: each result waits for the scan of the table memory,
//  one entry a cycle, over the whole table.
//  Reset clears the valid bits and loads the pools at once; no clearing pass.
//  A result stalled on out_ch holds the command in execute; once it moves to
//  the output register the next command is taken.
// ----------------------------------------------------------------------------
module resource_claim_grant_table_unit
  import rcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata,
  rcg_in_if.sink      in_ch,
  rcg_out_if.source   out_ch
);

  fsm_t state_r, state_nxt;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  cnt3_t                  pool_r;

  action_t          act_r;
  logic [TAG_W-1:0] tag_r;
  cnt3_t            amt_r;

  logic [SCN_W-1:0] scan_idx_r;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  entry_t           found_ent_r;
  logic             free_ok_r;
  logic [IDX_W-1:0] free_idx_r;

  logic       out_valid_r;
  status_t    out_status_r;
  cnt3_t      out_left_r;

  logic       in_fire;
  logic       out_take;
  logic       exec_fire;
  logic       rd_en;
  logic       scan_end;
  logic       hit;
  logic       hole;

  status_t          ex_status;
  cnt3_t            ex_pool;
  logic             ex_wr_en;
  logic [IDX_W-1:0] ex_wr_idx;
  entry_t           ex_wr_data;
  logic             ex_set;
  logic             ex_clr;
  logic             over_pool;
  logic             over_grant;
  cnt3_t            pool_sub;
  cnt3_t            pool_ret;
  cnt3_t            held_add;
  logic [CNT_W:0]   sum_w;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    in_fire     = in_ch.valid && (state_r == S_IDLE);
    out_take    = !out_valid_r || out_ch.ready;
    exec_fire   = (state_r == S_EXEC) && out_take;
    rd_en       = (state_r == S_SCAN) && (scan_idx_r != SCN_W'(TABLE_DEPTH));
    scan_end    = (state_r == S_SCAN) && (scan_idx_r == SCN_W'(TABLE_DEPTH)) && chk_vld_r;
    hit         = chk_vld_r && valid_r[chk_idx_r] && (rd_data_r.tag == tag_r);
    hole        = chk_vld_r && !valid_r[chk_idx_r];
  end

  // execute: checks and updates of one command
  always_comb begin
    over_pool  = 1'b0;
    over_grant = 1'b0;
    sum_w      = '0;
    for (int k = 0; k < NUM_RES; k++) begin
      if (amt_r[k] > pool_r[k]) begin
        over_pool = 1'b1;
      end
      if ({1'b0, amt_r[k]} + {1'b0, found_ent_r.held[k]} > {1'b0, found_ent_r.claim[k]}) begin
        over_grant = 1'b1;
      end
      pool_sub[k] = pool_r[k] - amt_r[k];
      held_add[k] = found_ent_r.held[k] + amt_r[k];
      sum_w       = {1'b0, pool_r[k]} + {1'b0, found_ent_r.held[k]};
      pool_ret[k] = sum_w[CNT_W] ? {CNT_W{1'b1}} : sum_w[CNT_W-1:0];
    end

    ex_status  = ST_OK;
    ex_pool    = pool_r;
    ex_wr_en   = 1'b0;
    ex_wr_idx  = found_idx_r;
    ex_wr_data = found_ent_r;
    ex_set     = 1'b0;
    ex_clr     = 1'b0;
    case (act_r)
      ACT_REGISTER: begin
        if (found_r) begin
          ex_status = ST_EXISTS;
        end else if (over_pool) begin
          ex_status = ST_OVER;
        end else if (!free_ok_r) begin
          ex_status = ST_FULL;
        end else begin
          ex_wr_en         = 1'b1;
          ex_set           = 1'b1;
          ex_wr_idx        = free_idx_r;
          ex_wr_data.tag   = tag_r;
          ex_wr_data.claim = amt_r;
          ex_wr_data.held  = '0;
        end
      end
      ACT_GRANT: begin
        if (!found_r) begin
          ex_status = ST_NOTFOUND;
        end else if (over_pool || over_grant) begin
          ex_status = ST_OVER;
        end else begin
          ex_pool         = pool_sub;
          ex_wr_en        = 1'b1;
          ex_wr_data.held = held_add;
        end
      end
      ACT_FINISH: begin
        if (!found_r) begin
          ex_status = ST_NOTFOUND;
        end else begin
          ex_pool = pool_ret;
          ex_clr  = 1'b1;
        end
      end
      default: ex_status = ST_OK;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
    if (exec_fire && ex_wr_en) begin
      mem[ex_wr_idx] <= ex_wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pool_r      <= {POOL_RST_C, POOL_RST_B, POOL_RST_A};
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= rd_en;
      if (in_fire) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        free_ok_r  <= 1'b0;
      end else if (rd_en) begin
        scan_idx_r <= scan_idx_r + SCN_W'(1);
      end
      if (hit && !found_r) begin
        found_r <= 1'b1;
      end
      if (hole && !free_ok_r) begin
        free_ok_r <= 1'b1;
      end
      if (exec_fire) begin
        pool_r <= ex_pool;
        if (ex_set) begin
          valid_r[ex_wr_idx] <= 1'b1;
        end
        if (ex_clr) begin
          valid_r[found_idx_r] <= 1'b0;
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_TOTAL_A: pool_r[0] <= CNT_W'(cfg_wdata);
          REG_TOTAL_B: pool_r[1] <= CNT_W'(cfg_wdata);
          REG_TOTAL_C: pool_r[2] <= CNT_W'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    chk_idx_r <= scan_idx_r[IDX_W-1:0];
    if (in_fire) begin
      act_r    <= action_t'(in_ch.action);
      tag_r    <= TAG_W'(in_ch.job_tag);
      amt_r[0] <= CNT_W'(in_ch.amount_a);
      amt_r[1] <= CNT_W'(in_ch.amount_b);
      amt_r[2] <= CNT_W'(in_ch.amount_c);
    end
    if (hit && !found_r) begin
      found_idx_r <= chk_idx_r;
      found_ent_r <= rd_data_r;
    end
    if (hole && !free_ok_r) begin
      free_idx_r <= chk_idx_r;
    end
    if (exec_fire) begin
      out_status_r <= ex_status;
      out_left_r   <= ex_pool;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.left_a = 8'(out_left_r[0]);
  assign out_ch.left_b = 8'(out_left_r[1]);
  assign out_ch.left_c = 8'(out_left_r[2]);

endmodule

### tb/tb_resource_claim_grant_table_unit.sv
// ----------------------------------------------------------------------------
// tb_resource_claim_grant_table_unit
// Self-checking bench for the job table. A ledger class keeps its own copy
// of the jobs and pools, works out the status and remaining pools for each
// command transfer, and compares them with each result transfer in order.
// A directed part covers the edge cases. Random phases with new totals
// follow, mostly well-formed job traffic, with bursty commands and a
// stalling receiver.
// ----------------------------------------------------------------------------
module tb_resource_claim_grant_table_unit;
  import rcg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 155;

  typedef struct packed {
    action_t          action;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] amount_a;
    logic [CNT_W-1:0] amount_b;
    logic [CNT_W-1:0] amount_c;
  } command_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] left_a;
    logic [CNT_W-1:0] left_b;
    logic [CNT_W-1:0] left_c;
  } outcome_t;

  class grant_ledger;
    bit               live    [TABLE_DEPTH];
    logic [TAG_W-1:0] job_tag [TABLE_DEPTH];
    cnt3_t            claim   [TABLE_DEPTH];
    cnt3_t            held    [TABLE_DEPTH];
    int               pool    [NUM_RES];
    outcome_t         owed_results [$];
    int               failures;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
      pool[0] = int'(POOL_RST_A);
      pool[1] = int'(POOL_RST_B);
      pool[2] = int'(POOL_RST_C);
      failures = 0;
    endfunction

    function void load_total(cfg_reg_t idx, logic [CNT_W-1:0] value);
      case (idx)
        REG_TOTAL_A: pool[0] = int'(value);
        REG_TOTAL_B: pool[1] = int'(value);
        REG_TOTAL_C: pool[2] = int'(value);
        default: ;
      endcase
    endfunction

    function int find_job(logic [TAG_W-1:0] tag);
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (live[i] && job_tag[i] == tag) return i;
      return -1;
    endfunction

    function void apply_command(command_t c);
      int       slot;
      int       amt [NUM_RES];
      bit       over;
      outcome_t r;
      amt[0] = int'(c.amount_a);
      amt[1] = int'(c.amount_b);
      amt[2] = int'(c.amount_c);
      r.status = ST_OK;
      slot = find_job(c.tag);
      over = 1'b0;
      case (c.action)
        ACT_REGISTER: begin
          if (slot >= 0) begin
            r.status = ST_EXISTS;
          end else begin
            for (int k = 0; k < NUM_RES; k++) if (amt[k] > pool[k]) over = 1'b1;
            if (over) begin
              r.status = ST_OVER;
            end else begin
              for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) if (!live[i]) slot = i;
              if (slot < 0) begin
                r.status = ST_FULL;
              end else begin
                live[slot]    = 1'b1;
                job_tag[slot] = c.tag;
                for (int k = 0; k < NUM_RES; k++) begin
                  claim[slot][k] = CNT_W'(amt[k]);
                  held[slot][k]  = '0;
                end
              end
            end
          end
        end
        ACT_GRANT: begin
          if (slot < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int k = 0; k < NUM_RES; k++)
              if (amt[k] > pool[k] ||
                  amt[k] + int'(held[slot][k]) > int'(claim[slot][k])) over = 1'b1;
            if (over) begin
              r.status = ST_OVER;
            end else begin
              for (int k = 0; k < NUM_RES; k++) begin
                pool[k]       -= amt[k];
                held[slot][k] = CNT_W'(int'(held[slot][k]) + amt[k]);
              end
            end
          end
        end
        ACT_FINISH: begin
          if (slot < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int k = 0; k < NUM_RES; k++) begin
              pool[k] += int'(held[slot][k]);
              if (pool[k] > 255) pool[k] = 255;
            end
            live[slot] = 1'b0;
          end
        end
        default: ;
      endcase
      r.left_a = CNT_W'(pool[0]);
      r.left_b = CNT_W'(pool[1]);
      r.left_c = CNT_W'(pool[2]);
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void match_result(logic [2:0] status, logic [CNT_W-1:0] left_a,
                               logic [CNT_W-1:0] left_b, logic [CNT_W-1:0] left_c);
      outcome_t want;
      if (owed_results.size() == 0) begin
        $error("status: expected no transfer, got %0d", status);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", 8'(want.status), 8'(status));
      compare_field("left_a", want.left_a, left_a);
      compare_field("left_b", want.left_b, left_b);
      compare_field("left_c", want.left_c, left_c);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [7:0]       cfg_wdata;
  rcg_in_if         in_ch ();
  rcg_out_if        out_ch ();

  grant_ledger      ledger;
  int               cycle_count = 0;
  int               burst_left  = 0;
  logic [TAG_W-1:0] tag_base    = '0;
  int               stall_left  = 0;
  logic             ready_level = 1'b0;

  resource_claim_grant_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL resource_claim_grant_table_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      ledger.match_result(out_ch.status, out_ch.left_a, out_ch.left_b, out_ch.left_c);
    if (stall_left == 0) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          ready_level = 1'b1;
          stall_left  = $urandom_range(300, 50);
        end
        3, 4, 5: begin
          ready_level = 1'b0;
          stall_left  = $urandom_range(60, 1);
        end
        default: begin
          ready_level = 1'($urandom_range(1));
          stall_left  = $urandom_range(6);
        end
      endcase
    end else begin
      stall_left--;
    end
    out_ch.ready <= ready_level;
  end

  function automatic command_t make_cmd(action_t act, logic [TAG_W-1:0] tag,
                                        logic [7:0] a, logic [7:0] b, logic [7:0] c);
    command_t cmd;
    cmd.action   = act;
    cmd.tag      = tag;
    cmd.amount_a = a;
    cmd.amount_b = b;
    cmd.amount_c = c;
    return cmd;
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int live_slots [$];
    int r;
    for (int i = 0; i < TABLE_DEPTH; i++) if (ledger.live[i]) live_slots.push_back(i);
    r = $urandom_range(99);
    if (r < 55 && live_slots.size() > 0)
      return ledger.job_tag[live_slots[$urandom_range(live_slots.size() - 1)]];
    if (r < 90) return TAG_W'(tag_base + TAG_W'($urandom_range(47)));
    return TAG_W'($urandom);
  endfunction

  function automatic command_t random_command(bit fill);
    command_t cmd;
    int       r;
    int       slot;
    int       room;
    int       amt [NUM_RES];
    int       live_slots [$];
    r = $urandom_range(99);
    cmd.tag = pick_tag();
    for (int k = 0; k < NUM_RES; k++) amt[k] = $urandom_range(255);
    if (r < (fill ? 65 : 35)) begin
      cmd.action = ACT_REGISTER;
      if ($urandom_range(4) != 0)
        for (int k = 0; k < NUM_RES; k++) amt[k] = $urandom_range(ledger.pool[k]);
    end else if (r < (fill ? 90 : 75)) begin
      cmd.action = ACT_GRANT;
      for (int i = 0; i < TABLE_DEPTH; i++) if (ledger.live[i]) live_slots.push_back(i);
      if (live_slots.size() > 0 && $urandom_range(4) != 0) begin
        slot    = live_slots[$urandom_range(live_slots.size() - 1)];
        cmd.tag = ledger.job_tag[slot];
        for (int k = 0; k < NUM_RES; k++) begin
          room = int'(ledger.claim[slot][k]) - int'(ledger.held[slot][k]);
          if (ledger.pool[k] < room) room = ledger.pool[k];
          amt[k] = $urandom_range(room);
          if ($urandom_range(15) == 0 && room < 255) amt[k] = room + 1;
        end
      end
    end else if (r < 97) begin
      cmd.action = ACT_FINISH;
    end else begin
      cmd.action = ACT_NONE;
    end
    cmd.amount_a = CNT_W'(amt[0]);
    cmd.amount_b = CNT_W'(amt[1]);
    cmd.amount_c = CNT_W'(amt[2]);
    return cmd;
  endfunction

  task automatic issue(command_t cmd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.action   <= cmd.action;
    in_ch.job_tag  <= cmd.tag;
    in_ch.amount_a <= cmd.amount_a;
    in_ch.amount_b <= cmd.amount_b;
    in_ch.amount_c <= cmd.amount_c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ledger.apply_command(cmd);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_totals(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    cfg_reg_t   regs [NUM_RES];
    logic [7:0] vals [NUM_RES];
    regs = '{REG_TOTAL_A, REG_TOTAL_B, REG_TOTAL_C};
    vals = '{a, b, c};
    for (int k = 0; k < NUM_RES; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
      ledger.load_total(regs[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    ledger = new();
    rst_n  = 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_TOTAL_A;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_NONE;
    in_ch.job_tag  <= '0;
    in_ch.amount_a <= '0;
    in_ch.amount_b <= '0;
    in_ch.amount_c <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(make_cmd(ACT_REGISTER, 16'h0000, 8'd10, 8'd5, 8'd7));
    issue(make_cmd(ACT_REGISTER, 16'h0000, 8'd1, 8'd1, 8'd1));
    issue(make_cmd(ACT_REGISTER, 16'hFFFF, 8'd11, 8'd0, 8'd0));
    issue(make_cmd(ACT_REGISTER, 16'hFFFF, 8'd0, 8'd0, 8'd0));
    issue(make_cmd(ACT_GRANT, 16'h1234, 8'd1, 8'd1, 8'd1));
    issue(make_cmd(ACT_GRANT, 16'h0000, 8'd10, 8'd5, 8'd7));
    issue(make_cmd(ACT_GRANT, 16'h0000, 8'd0, 8'd0, 8'd0));
    issue(make_cmd(ACT_GRANT, 16'hFFFF, 8'd0, 8'd0, 8'd1));
    issue(make_cmd(ACT_FINISH, 16'h5555, 8'd0, 8'd0, 8'd0));
    issue(make_cmd(ACT_NONE, 16'hFFFF, 8'd255, 8'd255, 8'd255));
    issue(make_cmd(ACT_FINISH, 16'h0000, 8'd255, 8'd255, 8'd255));
    issue(make_cmd(ACT_GRANT, 16'hFFFF, 8'd1, 8'd0, 8'd0));
    issue(make_cmd(ACT_FINISH, 16'hFFFF, 8'd0, 8'd0, 8'd0));
    settle();
    write_totals(8'd255, 8'd255, 8'd255);
    issue(make_cmd(ACT_REGISTER, 16'hAAAA, 8'd255, 8'd255, 8'd255));
    issue(make_cmd(ACT_GRANT, 16'hAAAA, 8'd255, 8'd255, 8'd255));
    issue(make_cmd(ACT_GRANT, 16'hAAAA, 8'd0, 8'd0, 8'd1));
    settle();
    write_totals(8'd255, 8'd255, 8'd255);
    issue(make_cmd(ACT_FINISH, 16'hAAAA, 8'd0, 8'd0, 8'd0));
    settle();
    write_totals(8'd0, 8'd0, 8'd0);
    issue(make_cmd(ACT_REGISTER, 16'h5555, 8'd0, 8'd0, 8'd1));
    issue(make_cmd(ACT_REGISTER, 16'h5555, 8'd0, 8'd0, 8'd0));
    issue(make_cmd(ACT_FINISH, 16'h5555, 8'd0, 8'd0, 8'd0));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: write_totals(8'($urandom), 8'($urandom), 8'($urandom));
        1: write_totals(8'($urandom_range(12)), 8'($urandom_range(12)),
                        8'($urandom_range(12)));
        2: write_totals(8'd255, 8'd255, 8'd255);
        default: begin
          if (p == 3) write_totals(8'd0, 8'd0, 8'd0);
          else write_totals(8'($urandom_range(120, 20)), 8'($urandom_range(120, 20)),
                            8'($urandom_range(120, 20)));
        end
      endcase
      tag_base = TAG_W'($urandom);
      repeat (PHASE_ITEMS) issue(random_command(p % 3 == 1));
      settle();
    end

    if (ledger.failures == 0) begin
      $display("PASS resource_claim_grant_table_unit");
    end else begin
      $display("FAIL resource_claim_grant_table_unit");
    end
    $finish;
  end

endmodule

### sim.f
design/rcg_pkg.sv
design/rcg_in_if.sv
design/rcg_out_if.sv
design/resource_claim_grant_table_unit.sv
tb/tb_resource_claim_grant_table_unit.sv
